/* sv/mrr_pkg.sv */
// Shared types and arithmetic helpers for the Miller-Rabin round block.
// No dependencies; used by every other file in sv/ except mrr_checker.sv.
package mrr_pkg;

   // operand width of the modular arithmetic
   localparam int NUM_WIDTH = 32;
   // bit counter for one modular product
   localparam int CNT_W = $clog2(NUM_WIDTH);
   // count of trailing zeros of n-1
   localparam int S_W = $clog2(NUM_WIDTH);

   typedef logic [NUM_WIDTH-1:0] num_type;

   // which operands feed the modular multiplier, and where the product goes
   typedef enum logic [1:0] {
      MUL_RES_BASE,
      MUL_BASE_BASE,
      MUL_X_X
   } mul_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        load;       // capture candidate and witness
      logic        init;       // d = n-1, s = 0, res = 1, base = a
      logic        split;      // d >>= 1, s++
      logic        take_x;     // x = res
      logic        step_sq;    // x = y, s--
      logic        mul_start;  // launch one modular product
      mul_sel_type mul_sel;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic n_le1;
      logic n_le3;
      logic n_even;
      logic a_bad;
      logic d_even;
      logic e_zero;
      logic e_lsb;
      logic mul_done;
      logic nontriv;   // x is a nontrivial square root of 1
      logic y_one;
      logic s_last;
   } sts_type;

   // (x + y) mod m for x, y < m
   function automatic num_type add_mod(num_type x, num_type y, num_type m);
      num_type room;
      room = m - y;
      return (x >= room) ? (x - room) : (x + y);
   endfunction

endpackage

/* sv/mrr_modmul.sv */
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Depends on mrr_pkg.
module mrr_modmul (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  mrr_pkg::num_type op_x,
   input  mrr_pkg::num_type op_y,
   input  mrr_pkg::num_type modulus,
   output logic             done,
   output mrr_pkg::num_type product
);

   mrr_pkg::num_type              acc_ff, acc_in;
   mrr_pkg::num_type              x_ff;
   mrr_pkg::num_type              y_ff;
   mrr_pkg::num_type              m_ff;
   logic [mrr_pkg::CNT_W-1:0]     cnt_ff;
   logic                          run_ff;
   logic                          done_ff;

   // double the accumulator, then add x when the multiplier bit is set
   always_comb begin
      acc_in = mrr_pkg::add_mod(acc_ff, acc_ff, m_ff);
      if (y_ff[mrr_pkg::NUM_WIDTH-1]) begin
         acc_in = mrr_pkg::add_mod(acc_in, x_ff, m_ff);
      end
   end

   // control: run flag and done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == '0) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // operands and accumulator
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         x_ff   <= op_x;
         y_ff   <= op_y;
         m_ff   <= modulus;
         cnt_ff <= mrr_pkg::CNT_W'(mrr_pkg::NUM_WIDTH - 1);
      end else if (run_ff) begin
         acc_ff <= acc_in;
         y_ff   <= {y_ff[mrr_pkg::NUM_WIDTH-2:0], 1'b0};
         cnt_ff <= cnt_ff - mrr_pkg::CNT_W'(1);
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

/* sv/mrr_dp.sv */
// Datapath: operand registers, exponent split, and the shared modular multiplier.
// Depends on mrr_pkg and mrr_modmul.
module mrr_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         candidate,
   input  logic [31:0]         witness,
   input  mrr_pkg::cmd_type    cmd,
   output mrr_pkg::sts_type    sts
);

   mrr_pkg::num_type          n_ff;
   mrr_pkg::num_type          a_ff;
   mrr_pkg::num_type          d_ff;
   mrr_pkg::num_type          res_ff;
   mrr_pkg::num_type          base_ff;
   mrr_pkg::num_type          x_ff;
   mrr_pkg::num_type          y_ff;
   logic [mrr_pkg::S_W-1:0]   s_ff;
   mrr_pkg::mul_sel_type      sel_ff;

   mrr_pkg::num_type          mul_x;
   mrr_pkg::num_type          mul_y;
   mrr_pkg::num_type          product;
   logic                      mul_done;

   // pick multiplier operands
   always_comb begin
      unique case (cmd.mul_sel)
         mrr_pkg::MUL_RES_BASE: begin
            mul_x = res_ff;
            mul_y = base_ff;
         end
         mrr_pkg::MUL_BASE_BASE: begin
            mul_x = base_ff;
            mul_y = base_ff;
         end
         default: begin
            mul_x = x_ff;
            mul_y = x_ff;
         end
      endcase
   end

   mrr_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .op_x    (mul_x),
      .op_y    (mul_y),
      .modulus (n_ff),
      .done    (mul_done),
      .product (product)
   );

   // operand and working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff <= mrr_pkg::NUM_WIDTH'(candidate);
         a_ff <= mrr_pkg::NUM_WIDTH'(witness);
      end
      if (cmd.init) begin
         d_ff    <= n_ff - mrr_pkg::NUM_WIDTH'(1);
         s_ff    <= '0;
         res_ff  <= mrr_pkg::NUM_WIDTH'(1);
         base_ff <= a_ff;
      end
      if (cmd.split) begin
         d_ff <= d_ff >> 1;
         s_ff <= s_ff + mrr_pkg::S_W'(1);
      end
      if (cmd.take_x) begin
         x_ff <= res_ff;
      end
      if (cmd.step_sq) begin
         x_ff <= y_ff;
         s_ff <= s_ff - mrr_pkg::S_W'(1);
      end
      if (cmd.mul_start) begin
         sel_ff <= cmd.mul_sel;
      end
      // write back the finished product; a base squaring also shifts the exponent right
      if (mul_done) begin
         unique case (sel_ff)
            mrr_pkg::MUL_RES_BASE: res_ff <= product;
            mrr_pkg::MUL_BASE_BASE: begin
               base_ff <= product;
               d_ff    <= d_ff >> 1;
            end
            default: y_ff <= product;
         endcase
      end
   end

   // status toward the controller
   always_comb begin
      sts.n_le1    = n_ff <= mrr_pkg::NUM_WIDTH'(1);
      sts.n_le3    = n_ff <= mrr_pkg::NUM_WIDTH'(3);
      sts.n_even   = ~n_ff[0];
      sts.a_bad    = (a_ff < mrr_pkg::NUM_WIDTH'(2)) || (a_ff > n_ff - mrr_pkg::NUM_WIDTH'(2));
      sts.d_even   = ~d_ff[0];
      sts.e_zero   = d_ff == '0;
      sts.e_lsb    = d_ff[0];
      sts.mul_done = mul_done;
      sts.nontriv  = (x_ff != mrr_pkg::NUM_WIDTH'(1)) && (y_ff == mrr_pkg::NUM_WIDTH'(1))
                     && (x_ff != n_ff - mrr_pkg::NUM_WIDTH'(1));
      sts.y_one    = y_ff == mrr_pkg::NUM_WIDTH'(1);
      sts.s_last   = s_ff == mrr_pkg::S_W'(1);
   end

endmodule

/* sv/mrr_ctrl.sv */
// Controller: sequences classification, exponent split, powering and squaring,
// and holds the result register. Depends on mrr_pkg.
module mrr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic             verdict,
   output logic             bad_witness,
   output mrr_pkg::cmd_type cmd,
   input  mrr_pkg::sts_type sts
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_SPLIT,
      ST_POW_CHK,
      ST_POW_MUL,
      ST_POW_SQR,
      ST_SQ_GO,
      ST_SQ_MUL,
      ST_SQ_CHK,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      pend_v_ff, pend_v_in;
   logic      pend_b_ff, pend_b_in;
   logic      out_v_ff;
   logic      out_b_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign req_tready = state_ff == ST_IDLE;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      pend_v_in = pend_v_ff;
      pend_b_in = pend_b_ff;
      cmd       = '0;
      cmd.mul_sel = mrr_pkg::MUL_X_X;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            pend_b_in = 1'b0;
            state_in  = ST_DONE;
            priority if (sts.n_le1) begin
               pend_v_in = 1'b0;
            end else if (sts.n_le3) begin
               pend_v_in = 1'b1;
            end else if (sts.n_even) begin
               pend_v_in = 1'b0;
            end else if (sts.a_bad) begin
               pend_v_in = 1'b0;
               pend_b_in = 1'b1;
            end else begin
               cmd.init = 1'b1;
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            if (sts.d_even) begin
               cmd.split = 1'b1;
            end else begin
               state_in = ST_POW_CHK;
            end
         end
         ST_POW_CHK: begin
            priority if (sts.e_zero) begin
               cmd.take_x = 1'b1;
               state_in   = ST_SQ_GO;
            end else if (sts.e_lsb) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = mrr_pkg::MUL_RES_BASE;
               state_in      = ST_POW_MUL;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = mrr_pkg::MUL_BASE_BASE;
               state_in      = ST_POW_SQR;
            end
         end
         ST_POW_MUL: begin
            if (sts.mul_done) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = mrr_pkg::MUL_BASE_BASE;
               state_in      = ST_POW_SQR;
            end
         end
         ST_POW_SQR: begin
            if (sts.mul_done) begin
               state_in = ST_POW_CHK;
            end
         end
         ST_SQ_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = mrr_pkg::MUL_X_X;
            state_in      = ST_SQ_MUL;
         end
         ST_SQ_MUL: begin
            if (sts.mul_done) begin
               state_in = ST_SQ_CHK;
            end
         end
         ST_SQ_CHK: begin
            pend_b_in = 1'b0;
            priority if (sts.nontriv) begin
               pend_v_in = 1'b0;
               state_in  = ST_DONE;
            end else if (sts.s_last) begin
               pend_v_in = sts.y_one;
               state_in  = ST_DONE;
            end else begin
               cmd.step_sq = 1'b1;
               state_in    = ST_SQ_GO;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state, pending verdict and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      pend_v_ff <= pend_v_in;
      pend_b_ff <= pend_b_in;
      if (state_ff == ST_DONE && out_free) begin
         out_v_ff <= pend_v_ff;
         out_b_ff <= pend_b_ff;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign verdict     = out_v_ff;
   assign bad_witness = out_b_ff;

endmodule

/* sv/miller_rabin_round.sv */
// Small, even and bad-witness cases go from CLASSIFY straight to DONE and the result register;
// a full round runs its modular products one after another in the shared multiplier
// (one bit per cycle), for the powering and the squaring of a 32-bit candidate.
// Throughput: one item at a time; the next transaction is taken once the result is queued.
// Reset: synchronous, active high; clears the controller and the result valid flag.
module miller_rabin_round (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] candidate, [63:32] witness
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] verdict, [1] bad_witness, [7:2] zero
);

   mrr_pkg::cmd_type cmd;
   mrr_pkg::sts_type sts;
   logic             verdict;
   logic             bad_witness;

   mrr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .verdict     (verdict),
      .bad_witness (bad_witness),
      .cmd         (cmd),
      .sts         (sts)
   );

   mrr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .candidate (req_tdata[31:0]),
      .witness   (req_tdata[63:32]),
      .cmd       (cmd),
      .sts       (sts)
   );

   assign rsp_tdata = {6'b0, bad_witness, verdict};

endmodule

/* sv/mrr_checker.sv */
// Port-level checks for miller_rabin_round, bound to the top level.
// Depends only on the top-level ports.
module mrr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a bad witness always comes with a composite verdict
   a_bad_comp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> !rsp_tdata[0])
      else $error("bad witness with prime verdict");

   // after an accepted transaction the block is busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken twice in a row");

   // reset clears the result channel
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind miller_rabin_round mrr_checker u_mrr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* bench/miller_rabin_round_test.sv */
// Self-checking bench for miller_rabin_round: a directed table, then random rounds.
// Depends on mrr_pkg for the operand width; drives the block through its stream ports.
module miller_rabin_round_test;

   typedef struct packed {
      logic verdict;
      logic bad_witness;
   } verdict_type;

   typedef struct {
      logic [31:0] candidate;
      logic [31:0] witness;
      logic        known;
      verdict_type want;
   } stim_row_type;

   localparam int DIRECTED = 22;
   localparam int RANDOM_ITEMS = 1200;
   localparam longint CYCLE_LIMIT = 64'd12_000_000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;

   verdict_type   pending_verdicts[$];
   stim_row_type  stim_table[DIRECTED];
   int            fail_count;
   longint        cycle_count;
   logic          quiet;

   miller_rabin_round u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   // exact modular product at double width
   function automatic logic [63:0] product_mod(logic [63:0] x, logic [63:0] y,
                                               logic [63:0] m);
      logic [127:0] full;
      full = x * y;
      return 64'(full % m);
   endfunction

   // one Miller-Rabin round at NUM_WIDTH bits
   function automatic verdict_type round_verdict(logic [31:0] cand, logic [31:0] wit);
      logic [63:0] mask, n, a, d, e, b, x, y;
      int          s;
      logic        comp;
      verdict_type r;
      mask = (mrr_pkg::NUM_WIDTH >= 64) ? '1 : ((64'd1 << mrr_pkg::NUM_WIDTH) - 1);
      n = {32'd0, cand} & mask;
      a = {32'd0, wit} & mask;
      r = '0;
      if (n <= 1) r.verdict = 1'b0;
      else if (n <= 3) r.verdict = 1'b1;
      else if (!n[0]) r.verdict = 1'b0;
      else if (a < 2 || a > n - 2) r.bad_witness = 1'b1;
      else begin
         d = n - 1;
         s = 0;
         while (!d[0]) begin
            d = d >> 1;
            s++;
         end
         // square-and-multiply for a^d
         x = 1;
         b = a % n;
         e = d;
         while (e != 0) begin
            if (e[0]) x = product_mod(x, b, n);
            e = e >> 1;
            b = product_mod(b, b, n);
         end
         y = 0;
         comp = 1'b0;
         for (int i = 0; i < s; i++) begin
            y = product_mod(x, x, n);
            if (x != 1 && y == 1 && x != n - 1) begin
               comp = 1'b1;
               break;
            end
            x = y;
         end
         if (!comp && y != 1) comp = 1'b1;
         r.verdict = !comp;
      end
      return r;
   endfunction

   // drive one transaction and hold until accepted; valid stays up for the next one
   task automatic send_round(logic [31:0] cand, logic [31:0] wit, bit allow_gap);
      if (allow_gap && !quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {wit, cand};
      pending_verdicts.push_back(round_verdict(cand, wit));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [31:0] odd_candidate();
      logic [31:0] c;
      case ($urandom_range(0, 3))
         0: c = $urandom_range(5, 255);
         1: c = $urandom_range(5, 65535);
         default: c = $urandom;
      endcase
      return c | 32'd1 | ((c < 5) ? 32'd5 : 32'd0);
   endfunction

   // random candidates are mostly odd with a legal witness
   task automatic send_random();
      logic [31:0] c, w;
      c = odd_candidate();
      w = (c > 4) ? 32'($urandom_range(2, c - 2)) : 32'd2;
      case ($urandom_range(0, 9))
         0: c = $urandom;
         1: w = $urandom;
         2: w = (c > 4) ? c - 1 : 32'd1;
         3: c = {c[31:1], 1'b0};
         4: w = $urandom_range(0, 1);
         default: ;
      endcase
      send_round(c, w, 1'b1);
   endtask

   // check results and stall at random on the result side
   always @(posedge clock) begin
      verdict_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = verdict_type'({rsp_tdata[0], rsp_tdata[1]});
            if (pending_verdicts.size() == 0) begin
               $error("unexpected result transaction: verdict %0b bad_witness %0b",
                      got.verdict, got.bad_witness);
               fail_count++;
            end else begin
               want = pending_verdicts.pop_front();
               if (got.verdict !== want.verdict) begin
                  $error("verdict: expected %0b, actual %0b", want.verdict, got.verdict);
                  fail_count++;
               end
               if (got.bad_witness !== want.bad_witness) begin
                  $error("bad_witness: expected %0b, actual %0b",
                         want.bad_witness, got.bad_witness);
                  fail_count++;
               end
            end
         end
         rsp_tready <= quiet ? 1'b1 : ($urandom_range(0, 4) != 0);
      end
   end

   // bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      stim_table = '{
         '{32'd0,          32'd0,          1'b1, '{1'b0, 1'b0}},
         '{32'd1,          32'hFFFFFFFF,   1'b1, '{1'b0, 1'b0}},
         '{32'd2,          32'd0,          1'b1, '{1'b1, 1'b0}},
         '{32'd3,          32'hFFFFFFFF,   1'b1, '{1'b1, 1'b0}},
         '{32'd4,          32'd2,          1'b1, '{1'b0, 1'b0}},
         '{32'hFFFFFFFE,   32'd7,          1'b1, '{1'b0, 1'b0}},
         '{32'd5,          32'd1,          1'b1, '{1'b0, 1'b1}},
         '{32'd5,          32'd4,          1'b1, '{1'b0, 1'b1}},
         '{32'd5,          32'd0,          1'b1, '{1'b0, 1'b1}},
         '{32'd7,          32'hFFFFFFFF,   1'b1, '{1'b0, 1'b1}},
         '{32'd5,          32'd2,          1'b0, '{1'b0, 1'b0}},
         '{32'd5,          32'd3,          1'b0, '{1'b0, 1'b0}},
         '{32'd9,          32'd2,          1'b0, '{1'b0, 1'b0}},
         '{32'd2047,       32'd2,          1'b0, '{1'b0, 1'b0}},
         '{32'd561,        32'd50,         1'b0, '{1'b0, 1'b0}},
         '{32'd97,         32'd95,         1'b0, '{1'b0, 1'b0}},
         '{32'hFFFFFFFB,   32'hFFFFFFF9,   1'b0, '{1'b0, 1'b0}},
         '{32'hFFFFFFFB,   32'd2,          1'b0, '{1'b0, 1'b0}},
         '{32'hFFFFFFFF,   32'h55555555,   1'b0, '{1'b0, 1'b0}},
         '{32'hFFFFFFFF,   32'hFFFFFFFD,   1'b0, '{1'b0, 1'b0}},
         '{32'h80000001,   32'hAAAAAAAA,   1'b0, '{1'b0, 1'b0}},
         '{32'd1105,       32'd1104,       1'b0, '{1'b0, 1'b0}}
      };
      fail_count = 0;
      cycle_count = 0;
      quiet = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed table; fixed rows must agree with the predictor too
      foreach (stim_table[i]) begin
         if (stim_table[i].known && round_verdict(stim_table[i].candidate,
               stim_table[i].witness) != stim_table[i].want) begin
            $error("directed row %0d: expected %0b%0b, predictor disagrees", i,
                   stim_table[i].want.verdict, stim_table[i].want.bad_witness);
            fail_count++;
         end
         send_round(stim_table[i].candidate, stim_table[i].witness, 1'b1);
      end
      req_tvalid <= 1'b0;

      // hold the sender until the block has drained
      while (pending_verdicts.size() != 0) @(posedge clock);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - 100) quiet = 1'b1;
         send_random();
      end
      req_tvalid <= 1'b0;

      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_verdicts.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
